@@ hdl/sbpd_pkg.sv @@
// Shared types and constants of the sync bit packet deframer.
// No dependencies; every other file of the block imports this package.
package sbpd_pkg;

  localparam int unsigned ByteWidth = 8;
  // Bit that marks a header (sync) byte and that is restored from the sign byte.
  localparam int unsigned SyncBit   = 7;
  localparam logic [ByteWidth-1:0] SyncMask = 8'h80;

  typedef logic [ByteWidth-1:0] byte_t;

  // Sign byte bit that carries bit 7 of each frame byte.
  localparam int unsigned SignHeader  = 6;
  localparam int unsigned SignAddress = 5;
  localparam int unsigned SignData0   = 4;
  localparam int unsigned SignCsum    = 0;

  typedef struct packed {
    byte_t header_byte;
    byte_t address_byte;
    byte_t payload0;
    byte_t payload1;
    byte_t payload2;
    byte_t payload3;
  } packet_t;

endpackage

@@ hdl/sbpd_if.sv @@
// Valid/ready channel interfaces of the sync bit packet deframer:
// one for received bytes and one for recovered packets. Depends on sbpd_pkg.
interface sbpd_byte_if import sbpd_pkg::*; ();
  logic  valid;
  logic  ready;
  byte_t rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface sbpd_pkt_if import sbpd_pkg::*; ();
  logic  valid;
  logic  ready;
  byte_t header_byte;
  byte_t address_byte;
  byte_t payload0;
  byte_t payload1;
  byte_t payload2;
  byte_t payload3;

  modport source (
    output valid, output header_byte, output address_byte,
    output payload0, output payload1, output payload2, output payload3,
    input ready
  );
  modport sink (
    input valid, input header_byte, input address_byte,
    input payload0, input payload1, input payload2, input payload3,
    output ready
  );
endinterface

@@ hdl/sbpd_frame_capture.sv @@
// Frame position tracking, byte capture, bit 7 restoration and checksum check.
// Depends on sbpd_pkg.
module sbpd_frame_capture import sbpd_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    accept_i,
  input  byte_t   rx_byte_i,
  output logic    push_o,
  output packet_t pkt_o
);

  typedef enum logic [2:0] {
    PosIdle,
    PosSign,
    PosAddr,
    PosData0,
    PosData1,
    PosData2,
    PosData3,
    PosCsum
  } pos_e;

  pos_e  pos_q, pos_d;
  byte_t header_q, sign_q, address_q;
  byte_t payload_q [4];
  logic  [1:0] data_idx;
  logic  is_sync, is_data;
  byte_t csum, sum;
  packet_t restored;

  assign is_sync = rx_byte_i[SyncBit];

  always_comb begin
    pos_d    = pos_q;
    data_idx = 2'd0;
    is_data  = 1'b0;
    case (pos_q)
      PosData0: begin data_idx = 2'd0; is_data = 1'b1; end
      PosData1: begin data_idx = 2'd1; is_data = 1'b1; end
      PosData2: begin data_idx = 2'd2; is_data = 1'b1; end
      PosData3: begin data_idx = 2'd3; is_data = 1'b1; end
      default: begin data_idx = 2'd0; is_data = 1'b0; end
    endcase
    if (accept_i) begin
      if (is_sync) begin
        pos_d = PosSign;
      end else begin
        case (pos_q)
          PosSign:  pos_d = PosAddr;
          PosAddr:  pos_d = PosData0;
          PosData0: pos_d = PosData1;
          PosData1: pos_d = PosData2;
          PosData2: pos_d = PosData3;
          PosData3: pos_d = PosCsum;
          default:  pos_d = PosIdle;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= PosIdle;
    end else begin
      pos_q <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      if (is_sync) begin
        header_q <= rx_byte_i;
      end else if (pos_q == PosSign) begin
        sign_q <= rx_byte_i;
      end else if (pos_q == PosAddr) begin
        address_q <= rx_byte_i;
      end else if (is_data) begin
        payload_q[data_idx] <= rx_byte_i;
      end
    end
  end

  // Every stored byte is written in each frame before its checksum byte
  // arrives, so the restored values come straight from the stores.
  always_comb begin
    restored.header_byte  = {sign_q[SignHeader],    header_q[SyncBit-1:0]};
    restored.address_byte = {sign_q[SignAddress],   address_q[SyncBit-1:0]};
    restored.payload0     = {sign_q[SignData0],     payload_q[0][SyncBit-1:0]};
    restored.payload1     = {sign_q[SignData0 - 1], payload_q[1][SyncBit-1:0]};
    restored.payload2     = {sign_q[SignData0 - 2], payload_q[2][SyncBit-1:0]};
    restored.payload3     = {sign_q[SignData0 - 3], payload_q[3][SyncBit-1:0]};
    csum = {sign_q[SignCsum], rx_byte_i[SyncBit-1:0]};
    sum  = byte_t'(restored.header_byte + restored.address_byte + restored.payload0
                   + restored.payload1 + restored.payload2 + restored.payload3);
  end

  assign push_o = accept_i && !is_sync && (pos_q == PosCsum) && (sum == csum);
  assign pkt_o  = restored;

endmodule

@@ hdl/sbpd_out_buffer.sv @@
// Two-entry output register with skid stage for recovered packets.
// Depends on sbpd_pkg.
module sbpd_out_buffer import sbpd_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  packet_t pkt_i,
  output logic    space_o,
  output logic    valid_o,
  input  logic    ready_i,
  output packet_t pkt_o
);

  logic    main_valid_q, main_valid_d;
  logic    skid_valid_q, skid_valid_d;
  packet_t main_q, main_d;
  packet_t skid_q, skid_d;
  logic    pop;

  assign pop = main_valid_q && ready_i;

  always_comb begin
    main_valid_d = main_valid_q;
    skid_valid_d = skid_valid_q;
    main_d       = main_q;
    skid_d       = skid_q;
    if (pop || !main_valid_q) begin
      if (skid_valid_q) begin
        main_d       = skid_q;
        main_valid_d = 1'b1;
        skid_d       = pkt_i;
        skid_valid_d = push_i;
      end else begin
        main_d       = pkt_i;
        main_valid_d = push_i;
      end
    end else if (push_i) begin
      skid_d       = pkt_i;
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      main_valid_q <= main_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    skid_q <= skid_d;
  end

  // A byte may only be taken while the skid entry is free.
  assign space_o = !skid_valid_q;
  assign valid_o = main_valid_q;
  assign pkt_o   = main_q;

endmodule

@@ hdl/sync_bit_packet_deframer_core.sv @@
// Sync bit packet deframer: takes one received byte per cycle while rx ready is
// high and emits a restored 6-byte packet after a checksum byte that matches.
// Depends on sbpd_pkg, sbpd_if, sbpd_frame_capture and sbpd_out_buffer.
//
// A frame is a header byte with bit 7 set, a sign byte, an address byte, four
// data bytes and a checksum byte; any byte with bit 7 set restarts the frame.
// The block takes one byte every cycle while rx ready is high. A packet whose
// checksum matches is presented on the output in the cycle after its checksum
// byte is transferred when the output register is free, and otherwise as soon
// as the packet ahead of it is taken; a mismatch produces nothing. The output
// side is a two-entry buffer (output register plus skid register), so bytes
// keep flowing while a packet waits; rx ready drops only when both entries
// hold packets not yet taken.
module sync_bit_packet_deframer_core import sbpd_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  sbpd_byte_if.sink  rx_i,
  sbpd_pkt_if.source pkt_o
);

  logic    accept;
  logic    push;
  logic    space;
  packet_t captured;
  packet_t buffered;

  assign accept   = rx_i.valid && rx_i.ready;
  assign rx_i.ready = space;

  sbpd_frame_capture u_capture (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .rx_byte_i (rx_i.rx_byte),
    .push_o    (push),
    .pkt_o     (captured)
  );

  sbpd_out_buffer u_out_buffer (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pkt_i   (captured),
    .space_o (space),
    .valid_o (pkt_o.valid),
    .ready_i (pkt_o.ready),
    .pkt_o   (buffered)
  );

  assign pkt_o.header_byte  = buffered.header_byte;
  assign pkt_o.address_byte = buffered.address_byte;
  assign pkt_o.payload0     = buffered.payload0;
  assign pkt_o.payload1     = buffered.payload1;
  assign pkt_o.payload2     = buffered.payload2;
  assign pkt_o.payload3     = buffered.payload3;

  // A packet is only produced by a byte transfer.
  assert property (@(posedge clk_i) disable iff (!rst_ni) push |-> accept)
    else $error("packet pushed without a byte transfer");

  // A full buffer means the output register is occupied.
  assert property (@(posedge clk_i) disable iff (!rst_ni) !rx_i.ready |-> pkt_o.valid)
    else $error("input stalled while output register is empty");

  // After a push, the output presents a packet in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni) push |=> pkt_o.valid)
    else $error("pushed packet not presented");

  // A byte with bit 7 set never yields a packet.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && rx_i.rx_byte[SyncBit]) |-> !push)
    else $error("sync byte produced a packet");

endmodule
